>>> hdl/rwcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwcr_pkg: shared types and constants of the radial warp coordinate remap
// Holds the item structs, the pipeline stage record, the stage plan and the
// one-step functions of the square root and divider units.
// ----------------------------------------------------------------------------
package rwcr_pkg;

   localparam int MAX_DIM    = 2048;
   localparam int FIELD_LIM  = 2048;
   localparam int LIM_CAP    = (MAX_DIM < FIELD_LIM) ? MAX_DIM : FIELD_LIM;

   // Register indexes of the control port.
   localparam logic [2:0] CSR_WARP_MODE    = 3'd0;
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd1;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_CENTER_X     = 3'd3;
   localparam logic [2:0] CSR_CENTER_Y     = 3'd4;
   localparam logic [2:0] CSR_BULGE_RADIUS = 3'd5;

   localparam logic MODE_BULGE = 1'b0;
   localparam logic MODE_PINCH = 1'b1;

   // Stage plan of the pipeline.
   localparam int ST_D2       = 1;
   localparam int ST_SQA      = 2;
   localparam int SQA_STEPS   = 18;
   localparam int ST_SQB_INIT = ST_SQA + SQA_STEPS;
   localparam int SQB_STEPS   = 9;
   localparam int ST_SQR      = ST_SQB_INIT + 1 + SQB_STEPS;
   localparam int ST_NUM      = ST_SQR + 1;
   localparam int ST_DIV      = ST_NUM + 1;
   localparam int DIV_STEPS   = 18;
   localparam int ST_SQC_INIT = ST_DIV + DIV_STEPS;
   localparam int SQC_STEPS   = 9;
   localparam int NUM_STAGES  = ST_SQC_INIT + 1 + SQC_STEPS;

   typedef struct packed {
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
   } rwcr_req_type;

   typedef struct packed {
      logic [10:0] source_x;
      logic [10:0] source_y;
      logic        inside_radius;
   } rwcr_rsp_type;

   typedef struct packed {
      logic [35:0] rad;
      logic [20:0] rem;
      logic [17:0] root;
   } rwcr_sqrt_type;

   typedef struct packed {
      logic [23:0] rem;
      logic [17:0] low;
      logic [17:0] quo;
   } rwcr_div_type;

   typedef struct packed {
      logic          mode;
      logic [10:0]   px;
      logic [10:0]   py;
      logic          xneg;
      logic          yneg;
      logic [10:0]   xmag;
      logic [10:0]   ymag;
      logic [21:0]   dx2;
      logic [21:0]   dy2;
      logic [22:0]   d2;
      logic [17:0]   s1;
      logic [17:0]   r2sq;
      logic [22:0]   dv;
      logic          in_radius;
      logic          dzero;
      rwcr_div_type  xdiv;
      rwcr_div_type  ydiv;
      rwcr_sqrt_type sqa;
      rwcr_sqrt_type sqb;
   } rwcr_stage_type;

   // One digit of a restoring square root; the radicand is left-justified.
   function automatic rwcr_sqrt_type sqrt_step(input rwcr_sqrt_type s);
      rwcr_sqrt_type r;
      logic [20:0]   t_rem;
      logic [20:0]   trial;
      t_rem = {s.rem[18:0], s.rad[35:34]};
      trial = {1'b0, s.root, 2'b01};
      r.rad = {s.rad[33:0], 2'b00};
      if (t_rem >= trial) begin
         r.rem  = t_rem - trial;
         r.root = {s.root[16:0], 1'b1};
      end else begin
         r.rem  = t_rem;
         r.root = {s.root[16:0], 1'b0};
      end
      return r;
   endfunction

   // One quotient bit of a restoring division.
   function automatic rwcr_div_type div_step(input rwcr_div_type d, input logic [22:0] dv);
      rwcr_div_type r;
      logic [23:0]  t;
      t     = {d.rem[22:0], d.low[17]};
      r.low = {d.low[16:0], 1'b0};
      if (t >= {1'b0, dv}) begin
         r.rem = t - {1'b0, dv};
         r.quo = {d.quo[16:0], 1'b1};
      end else begin
         r.rem = t;
         r.quo = {d.quo[16:0], 1'b0};
      end
      return r;
   endfunction

endpackage

>>> hdl/radial_warp_coordinate_remap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_warp_coordinate_remap: bulge and pinch source coordinate generator
// Maps each destination pixel to the source pixel to fetch for a radial warp.
// ----------------------------------------------------------------------------
// This block takes one destination pixel item per clock while the result
// side does not stall and returns one source coordinate item per pixel, in
// order. The work is done by bit-serial units laid out as pipeline stages:
// an 18-digit square root of 4096*d2, a 9-digit root of that, an 18-bit
// restoring divider per axis and a final 9-digit root per axis. Sustained
// throughput is one item per cycle while the result side does not stall.
// A stall on the result side freezes the whole pipeline, so nothing is lost
// or repeated. In bulge mode a pixel inside the radius is pulled toward the
// center by the factor sqrt(d2)/radius and others pass unchanged with
// inside_radius low; in pinch mode the offset is scaled to 8*d2^(1/4) and
// the result is clamped to the image. Registers must be written while idle.
// ----------------------------------------------------------------------------
module radial_warp_coordinate_remap (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rwcr_pkg::rwcr_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rwcr_pkg::rwcr_rsp_type rsp_data,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [11:0]           csr_wdata
);

   localparam int NST = rwcr_pkg::NUM_STAGES;

   // Configuration registers.
   logic        warp_mode_ff;
   logic [11:0] image_width_ff;
   logic [11:0] image_height_ff;
   logic [10:0] center_x_ff;
   logic [10:0] center_y_ff;
   logic [11:0] bulge_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         warp_mode_ff    <= rwcr_pkg::MODE_BULGE;
         image_width_ff  <= 12'd2048;
         image_height_ff <= 12'd2048;
         center_x_ff     <= 11'd1024;
         center_y_ff     <= 11'd1024;
         bulge_radius_ff <= 12'd1448;
      end else if (csr_we) begin
         unique case (csr_index)
            rwcr_pkg::CSR_WARP_MODE:    warp_mode_ff    <= csr_wdata[0];
            rwcr_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            rwcr_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            rwcr_pkg::CSR_CENTER_X:     center_x_ff     <= csr_wdata[10:0];
            rwcr_pkg::CSR_CENTER_Y:     center_y_ff     <= csr_wdata[10:0];
            rwcr_pkg::CSR_BULGE_RADIUS: bulge_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves together unless a finished item is held.
   logic advance;
   logic rsp_valid_ff;
   rwcr_pkg::rwcr_rsp_type rsp_data_ff;
   rwcr_pkg::rwcr_rsp_type rsp_data_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   rwcr_pkg::rwcr_stage_type stage_ff [NST];
   rwcr_pkg::rwcr_stage_type stage_in [NST];
   logic                     vld_ff   [NST];

   genvar i;
   generate
      for (i = 0; i < NST; i++) begin : g_stage
         if (i == 0) begin : g_delta
            // Signed offsets from the center as sign and magnitude, and squares.
            always_comb begin
               stage_in[i]      = '0;
               stage_in[i].mode = warp_mode_ff;
               stage_in[i].px   = req_data.pixel_x;
               stage_in[i].py   = req_data.pixel_y;
               stage_in[i].xneg = req_data.pixel_x < center_x_ff;
               stage_in[i].yneg = req_data.pixel_y < center_y_ff;
               stage_in[i].xmag = stage_in[i].xneg ? center_x_ff - req_data.pixel_x
                                                   : req_data.pixel_x - center_x_ff;
               stage_in[i].ymag = stage_in[i].yneg ? center_y_ff - req_data.pixel_y
                                                   : req_data.pixel_y - center_y_ff;
               stage_in[i].dx2  = 22'(stage_in[i].xmag) * 22'(stage_in[i].xmag);
               stage_in[i].dy2  = 22'(stage_in[i].ymag) * 22'(stage_in[i].ymag);
            end
         end else if (i == rwcr_pkg::ST_D2) begin : g_d2
            always_comb begin
               stage_in[i]          = stage_ff[i-1];
               stage_in[i].d2       = 23'(stage_ff[i-1].dx2) + 23'(stage_ff[i-1].dy2);
               stage_in[i].sqa.rad  = {1'b0, stage_in[i].d2, 12'b0};
               stage_in[i].sqa.rem  = '0;
               stage_in[i].sqa.root = '0;
            end
         end else if (i == rwcr_pkg::ST_SQB_INIT) begin : g_sqb_init
            // The first root is floor(64*sqrt(d2)); keep it, then take its root.
            always_comb begin
               stage_in[i]          = stage_ff[i-1];
               stage_in[i].s1       = stage_ff[i-1].sqa.root;
               stage_in[i].sqa.rad  = {stage_ff[i-1].sqa.root, 18'b0};
               stage_in[i].sqa.rem  = '0;
               stage_in[i].sqa.root = '0;
            end
         end else if (i == rwcr_pkg::ST_SQR) begin : g_r2sq
            always_comb begin
               stage_in[i]      = stage_ff[i-1];
               stage_in[i].r2sq = 18'(stage_ff[i-1].sqa.root[8:0])
                                * 18'(stage_ff[i-1].sqa.root[8:0]);
            end
         end else if (i == rwcr_pkg::ST_NUM) begin : g_num
            // Bulge divides delta*dis by the radius, pinch divides r2sq*delta^2 by d2.
            logic [11:0] dis;
            logic [39:0] numx;
            logic [39:0] numy;
            always_comb begin
               dis = stage_ff[i-1].s1[17:6];
               if (stage_ff[i-1].mode == rwcr_pkg::MODE_PINCH) begin
                  numx = 40'(stage_ff[i-1].r2sq) * 40'(stage_ff[i-1].dx2);
                  numy = 40'(stage_ff[i-1].r2sq) * 40'(stage_ff[i-1].dy2);
               end else begin
                  numx = 40'(23'(stage_ff[i-1].xmag) * 23'(dis));
                  numy = 40'(23'(stage_ff[i-1].ymag) * 23'(dis));
               end
               stage_in[i]           = stage_ff[i-1];
               stage_in[i].in_radius = (stage_ff[i-1].mode == rwcr_pkg::MODE_PINCH)
                                    || (dis < bulge_radius_ff);
               stage_in[i].dv     = (stage_ff[i-1].mode == rwcr_pkg::MODE_PINCH)
                                 ? stage_ff[i-1].d2 : 23'(bulge_radius_ff);
               stage_in[i].dzero  = stage_ff[i-1].d2 == '0;
               stage_in[i].xdiv   = '{rem: 24'(numx[39:18]), low: numx[17:0], quo: '0};
               stage_in[i].ydiv   = '{rem: 24'(numy[39:18]), low: numy[17:0], quo: '0};
            end
         end else if (i == rwcr_pkg::ST_SQC_INIT) begin : g_sqc_init
            always_comb begin
               stage_in[i]          = stage_ff[i-1];
               stage_in[i].sqa.rad  = {stage_ff[i-1].xdiv.quo, 18'b0};
               stage_in[i].sqa.rem  = '0;
               stage_in[i].sqa.root = '0;
               stage_in[i].sqb.rad  = {stage_ff[i-1].ydiv.quo, 18'b0};
               stage_in[i].sqb.rem  = '0;
               stage_in[i].sqb.root = '0;
            end
         end else if (i >= rwcr_pkg::ST_DIV && i < rwcr_pkg::ST_SQC_INIT) begin : g_div
            always_comb begin
               stage_in[i]      = stage_ff[i-1];
               stage_in[i].xdiv = rwcr_pkg::div_step(stage_ff[i-1].xdiv, stage_ff[i-1].dv);
               stage_in[i].ydiv = rwcr_pkg::div_step(stage_ff[i-1].ydiv, stage_ff[i-1].dv);
            end
         end else if (i > rwcr_pkg::ST_SQC_INIT) begin : g_sqc
            always_comb begin
               stage_in[i]     = stage_ff[i-1];
               stage_in[i].sqa = rwcr_pkg::sqrt_step(stage_ff[i-1].sqa);
               stage_in[i].sqb = rwcr_pkg::sqrt_step(stage_ff[i-1].sqb);
            end
         end else begin : g_sqab
            // Digit steps of the first and second square roots.
            always_comb begin
               stage_in[i]     = stage_ff[i-1];
               stage_in[i].sqa = rwcr_pkg::sqrt_step(stage_ff[i-1].sqa);
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               stage_ff[i] <= stage_in[i];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else if (advance) begin
               vld_ff[i] <= (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i-1];
            end
         end
      end
   endgenerate

   // Final stage: apply the offsets, select bulge or pinch, and clamp.
   rwcr_pkg::rwcr_stage_type last;
   logic [11:0]        lim_x;
   logic [11:0]        lim_y;
   logic [8:0]         off_x;
   logic [8:0]         off_y;
   logic signed [12:0] vx;
   logic signed [12:0] vy;
   logic [10:0]        bx;
   logic [10:0]        by;
   logic [10:0]        cl_x;
   logic [10:0]        cl_y;

   always_comb begin
      last  = stage_ff[NST-1];
      lim_x = (image_width_ff == '0) ? 12'd1
            : (image_width_ff > 12'(rwcr_pkg::LIM_CAP)) ? 12'(rwcr_pkg::LIM_CAP)
            : image_width_ff;
      lim_y = (image_height_ff == '0) ? 12'd1
            : (image_height_ff > 12'(rwcr_pkg::LIM_CAP)) ? 12'(rwcr_pkg::LIM_CAP)
            : image_height_ff;
      off_x = last.dzero ? 9'd0 : last.sqa.root[8:0];
      off_y = last.dzero ? 9'd0 : last.sqb.root[8:0];
      vx = last.xneg ? $signed({2'b00, center_x_ff}) - $signed({4'b0000, off_x})
                     : $signed({2'b00, center_x_ff}) + $signed({4'b0000, off_x});
      vy = last.yneg ? $signed({2'b00, center_y_ff}) - $signed({4'b0000, off_y})
                     : $signed({2'b00, center_y_ff}) + $signed({4'b0000, off_y});
      priority if (vx < 0) begin
         cl_x = '0;
      end else if (vx >= $signed({1'b0, lim_x})) begin
         cl_x = 11'(lim_x - 12'd1);
      end else begin
         cl_x = vx[10:0];
      end
      priority if (vy < 0) begin
         cl_y = '0;
      end else if (vy >= $signed({1'b0, lim_y})) begin
         cl_y = 11'(lim_y - 12'd1);
      end else begin
         cl_y = vy[10:0];
      end
      bx = last.xneg ? center_x_ff - last.xdiv.quo[10:0] : center_x_ff + last.xdiv.quo[10:0];
      by = last.yneg ? center_y_ff - last.ydiv.quo[10:0] : center_y_ff + last.ydiv.quo[10:0];
      if (last.mode == rwcr_pkg::MODE_PINCH) begin
         rsp_data_in = '{source_x: cl_x, source_y: cl_y, inside_radius: 1'b1};
      end else if (last.in_radius) begin
         rsp_data_in = '{source_x: bx, source_y: by, inside_radius: 1'b1};
      end else begin
         rsp_data_in = '{source_x: last.px, source_y: last.py, inside_radius: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A finished item that moves out of the pipeline shows up at the output.
   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST-1] && advance |=> rsp_valid)
      else $error("finished item did not reach the output register");

   // Pinch mode remaps every pixel.
   a_pinch_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && warp_mode_ff == rwcr_pkg::MODE_PINCH |-> rsp_data.inside_radius)
      else $error("pinch item reported outside the radius");

   // Pinch results stay inside a legal image width.
   a_pinch_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && warp_mode_ff == rwcr_pkg::MODE_PINCH && image_width_ff != '0
      && image_width_ff <= 12'(rwcr_pkg::LIM_CAP)
      |-> 12'(rsp_data.source_x) < image_width_ff)
      else $error("pinch source column outside the image");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the radial warp coordinate remap
// Drives pixel items in random bursts against a stalling receiver, predicts
// the source coordinate of each item with an exact integer model of the bulge
// and pinch warps, and compares every result field by field in order.
// ----------------------------------------------------------------------------
module testbench;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   rwcr_pkg::rwcr_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rwcr_pkg::rwcr_rsp_type rsp_data;
   logic                   csr_we = 1'b0;
   logic [2:0]             csr_index = '0;
   logic [11:0]            csr_wdata = '0;

   // Local copy of the control registers, kept in step with every write.
   logic        cur_mode;
   logic [11:0] cur_width, cur_height, cur_radius;
   logic [10:0] cur_cx, cur_cy;

   rwcr_pkg::rwcr_rsp_type expected_coords[$];
   int mismatch_count = 0;
   int result_count = 0;
   int item_count = 0;
   int cycle_count = 0;
   int pinch_items = 0;
   int bulge_items = 0;
   bit stall_enable = 1'b1;

   localparam int LATENCY = 61;
   localparam int CYCLE_LIMIT = 400000;

   radial_warp_coordinate_remap u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bit-by-bit integer square root, floor of the true root.
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint pinch_shift(input longint delta, input longint unsigned r2sq,
                                          input longint unsigned d2);
      longint unsigned mag;
      longint unsigned q;
      if (d2 == 0) return 0;
      mag = (delta < 0) ? -delta : delta;
      q = int_sqrt((r2sq * mag * mag) / d2);
      return (delta < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [10:0] clamp_to_image(input longint v, input longint dim);
      longint lim;
      lim = dim;
      if (lim > rwcr_pkg::LIM_CAP) lim = rwcr_pkg::LIM_CAP;
      if (lim < 1) lim = 1;
      if (v < 0) return '0;
      if (v >= lim) return 11'(lim - 1);
      return 11'(v);
   endfunction

   function automatic rwcr_pkg::rwcr_rsp_type warp_source(input rwcr_pkg::rwcr_req_type pix);
      rwcr_pkg::rwcr_rsp_type r;
      longint dx, dy, dis, rad;
      longint unsigned d2, r2;
      dx = longint'(pix.pixel_x) - longint'(cur_cx);
      dy = longint'(pix.pixel_y) - longint'(cur_cy);
      d2 = dx * dx + dy * dy;
      if (cur_mode == rwcr_pkg::MODE_BULGE) begin
         dis = int_sqrt(d2);
         rad = cur_radius;
         if (rad > 0 && dis < rad) begin
            r.source_x = 11'(longint'(cur_cx) + (dx * dis) / rad);
            r.source_y = 11'(longint'(cur_cy) + (dy * dis) / rad);
            r.inside_radius = 1'b1;
         end else begin
            r.source_x = pix.pixel_x;
            r.source_y = pix.pixel_y;
            r.inside_radius = 1'b0;
         end
      end else begin
         r2 = int_sqrt(int_sqrt(64'd4096 * d2));
         r.source_x = clamp_to_image(longint'(cur_cx) + pinch_shift(dx, r2 * r2, d2),
                                     cur_width);
         r.source_y = clamp_to_image(longint'(cur_cy) + pinch_shift(dy, r2 * r2, d2),
                                     cur_height);
         r.inside_radius = 1'b1;
      end
      return r;
   endfunction

   // Receiver stall pattern: a free-running counter picks long runs of heavy,
   // light or no stalling so every pipeline phase sees back pressure.
   always @(negedge clock) begin
      int phase;
      phase = (cycle_count / 97) % 3;
      if (!stall_enable || phase == 0) rsp_stall <= 1'b0;
      else if (phase == 1) rsp_stall <= ($urandom_range(0, 9) < 6);
      else rsp_stall <= ($urandom_range(0, 9) < 1);
   end

   // Result checker: each accepted result is matched with the oldest prediction.
   always @(posedge clock) begin
      rwcr_pkg::rwcr_rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count <= result_count + 1;
         if (expected_coords.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = expected_coords.pop_front();
            if (rsp_data.source_x !== want.source_x || rsp_data.source_y !== want.source_y
                || rsp_data.inside_radius !== want.inside_radius) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("result mismatch: expected x=%0d y=%0d in=%0d, got x=%0d y=%0d in=%0d",
                           want.source_x, want.source_y, want.inside_radius,
                           rsp_data.source_x, rsp_data.source_y, rsp_data.inside_radius);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Sends one pixel item; the prediction is queued when the item is accepted.
   task automatic send_pixel(input logic [10:0] px, input logic [10:0] py);
      rwcr_pkg::rwcr_req_type pix;
      pix.pixel_x = px;
      pix.pixel_y = py;
      req_data  <= pix;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_coords.push_back(warp_source(pix));
      item_count++;
      if (cur_mode == rwcr_pkg::MODE_PINCH) pinch_items++; else bulge_items++;
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Waits until every result has come back, then lets the pipe drain.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_coords.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [11:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      unique case (idx)
         rwcr_pkg::CSR_WARP_MODE:    cur_mode   = value[0];
         rwcr_pkg::CSR_IMAGE_WIDTH:  cur_width  = value;
         rwcr_pkg::CSR_IMAGE_HEIGHT: cur_height = value;
         rwcr_pkg::CSR_CENTER_X:     cur_cx     = value[10:0];
         rwcr_pkg::CSR_CENTER_Y:     cur_cy     = value[10:0];
         rwcr_pkg::CSR_BULGE_RADIUS: cur_radius = value;
         default: ;
      endcase
   endtask

   task automatic set_geometry(input logic mode, input logic [11:0] w, input logic [11:0] h,
                               input logic [10:0] cx, input logic [10:0] cy,
                               input logic [11:0] rad);
      drain_pipeline();
      write_register(rwcr_pkg::CSR_WARP_MODE, {11'd0, mode});
      write_register(rwcr_pkg::CSR_IMAGE_WIDTH, w);
      write_register(rwcr_pkg::CSR_IMAGE_HEIGHT, h);
      write_register(rwcr_pkg::CSR_CENTER_X, {1'b0, cx});
      write_register(rwcr_pkg::CSR_CENTER_Y, {1'b0, cy});
      write_register(rwcr_pkg::CSR_BULGE_RADIUS, rad);
   endtask

   // Corners, edge midpoints, the center and a point next to it under the reset settings.
   task automatic test_reset_bulge();
      send_pixel(11'd0, 11'd0);
      send_pixel(11'd2047, 11'd2047);
      send_pixel(11'd1024, 11'd1024);
      send_pixel(11'd1025, 11'd1023);
      send_pixel(11'd0, 11'd2047);
      send_pixel(11'd2047, 11'd1024);
      send_pixel(11'd1024, 11'd0);
   endtask

   // Bulge with the smallest radius and the zero radius: nearly all pass through.
   task automatic test_bulge_radius_edges();
      set_geometry(rwcr_pkg::MODE_BULGE, 12'd2048, 12'd2048, 11'd0, 11'd2047, 12'd1);
      send_pixel(11'd0, 11'd2047);
      send_pixel(11'd1, 11'd2047);
      send_pixel(11'd2047, 11'd0);
      set_geometry(rwcr_pkg::MODE_BULGE, 12'd2048, 12'd2048, 11'd500, 11'd600, 12'd0);
      send_pixel(11'd500, 11'd600);
      send_pixel(11'd501, 11'd600);
   endtask

   // Pinch at the center and at far corners, with clamping to tiny and odd frames.
   task automatic test_pinch_clamping();
      set_geometry(rwcr_pkg::MODE_PINCH, 12'd2048, 12'd2048, 11'd2047, 11'd0, 12'd2048);
      send_pixel(11'd2047, 11'd0);
      send_pixel(11'd0, 11'd2047);
      send_pixel(11'd2046, 11'd1);
      set_geometry(rwcr_pkg::MODE_PINCH, 12'd1, 12'd0, 11'd1024, 11'd1024, 12'd4095);
      send_pixel(11'd0, 11'd0);
      send_pixel(11'd2047, 11'd2047);
      set_geometry(rwcr_pkg::MODE_PINCH, 12'd4095, 12'd100, 11'd50, 11'd90, 12'd7);
      send_pixel(11'd2047, 11'd2047);
      send_pixel(11'd0, 11'd0);
   endtask

   // Random pixels in bursts under a sequence of random and extreme settings.
   task automatic test_random_warps();
      int burst;
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 9)
            set_geometry(rwcr_pkg::MODE_BULGE, 12'd2048, 12'd2048, 11'd1024, 11'd1024,
                         12'd1448);
         else
            set_geometry(phase[0], 12'($urandom_range(0, 4095)),
                         12'($urandom_range(0, 4095)), 11'($urandom), 11'($urandom),
                         (phase == 4) ? 12'd4095 : 12'($urandom_range(1, 2048)));
         stall_enable = (phase != 3);
         for (int k = 0; k < 43; k++) begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0) burst = 0;
            if (burst == 0) pause_sender($urandom_range(1, 6));
            if (k == 20 && phase == 2) begin
               req_valid <= 1'b0;
               while (expected_coords.size() != 0) @(negedge clock);
            end
            if ($urandom_range(0, 1))
               send_pixel(11'($urandom), 11'($urandom));
            else
               send_pixel(11'(cur_cx + $urandom_range(0, 60) - 30),
                          11'(cur_cy + $urandom_range(0, 60) - 30));
         end
      end
      stall_enable = 1'b1;
   endtask

   initial begin
      cur_mode   = rwcr_pkg::MODE_BULGE;
      cur_width  = 12'd2048;
      cur_height = 12'd2048;
      cur_cx     = 11'd1024;
      cur_cy     = 11'd1024;
      cur_radius = 12'd1448;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_bulge();
      test_bulge_radius_edges();
      test_pinch_clamping();
      test_random_warps();
      drain_pipeline();
      $display("Sent %0d pixel items (%0d bulge, %0d pinch), checked %0d results.",
               item_count, bulge_items, pinch_items, result_count);
      if (mismatch_count == 0 && expected_coords.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
